// File: hw/rtl/base64_stream_encoder_core_macros.svh
// Assertion macros shared by the base64 stream encoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset
`define B64SE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset
`define B64SE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/b64se_pkg.sv
// Shared types, constants and the sextet-to-ASCII mapping for the base64 encoder.
// No dependencies; imported by every module of the encoder.
`default_nettype none

package b64se_pkg;

    // Number of bytes held in one group word
    typedef enum logic [1:0] {
        GRP_ONE  = 2'd1,
        GRP_TWO  = 2'd2,
        GRP_FULL = 2'd3
    } t_grp_kind;

    // One completed group, missing bytes are zero
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        t_grp_kind  kind;
        logic       eom;
    } t_grp;

    // Front-end status seen by the top level
    typedef struct packed {
        logic [1:0] held_cnt;
        logic       push;
    } t_front_stat;

    localparam logic [6:0] PAD_CHAR      = 7'd61;
    localparam logic [1:0] CHAR_IDX_LAST = 2'd3;
    localparam logic [1:0] QUEUE_DEPTH   = 2'd2;

    // Base64 alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            return w + 7'd65;
        end else if (v < 6'd52) begin
            return w + 7'd71;
        end else if (v < 6'd62) begin
            return w - 7'd4;
        end else if (v == 6'd62) begin
            return 7'd43;
        end else begin
            return 7'd47;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b64se_front.sv
// Front end: accepts bytes, gathers them into groups of up to three, pushes groups.
// Depends on b64se_pkg.
`default_nettype none

module b64se_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_tvalid,
    output logic                      o_s_tready,
    input  wire  [7:0]                i_data_byte,
    input  wire                       i_end_of_message,
    input  wire                       i_q_full,
    output logic                      o_push,
    output b64se_pkg::t_grp           o_grp,
    output b64se_pkg::t_front_stat    o_stat
);
    import b64se_pkg::*;

    logic [15:0] r_pend;
    logic [15:0] n_pend;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_accept;
    logic        w_done;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && !i_q_full;
    // group closes on the third byte or on the end mark
    assign w_done     = (r_cnt >= 2'd2) || i_end_of_message;

    // classify the incoming byte and build the group word
    always_comb begin
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        o_push       = 1'b0;
        o_grp.b0     = r_pend[15:8];
        o_grp.b1     = r_pend[7:0];
        o_grp.b2     = i_data_byte;
        o_grp.kind   = GRP_FULL;
        o_grp.eom    = i_end_of_message;
        case (r_cnt)
            2'd0: begin
                o_grp.b0   = i_data_byte;
                o_grp.b1   = 8'd0;
                o_grp.b2   = 8'd0;
                o_grp.kind = GRP_ONE;
            end
            2'd1: begin
                o_grp.b1   = i_data_byte;
                o_grp.b2   = 8'd0;
                o_grp.kind = GRP_TWO;
            end
            default: begin
                o_grp.kind = GRP_FULL;
            end
        endcase
        if (w_accept) begin
            if (w_done) begin
                o_push = 1'b1;
                n_pend = 16'd0;
                n_cnt  = 2'd0;
            end else begin
                if (r_cnt == 2'd0) begin
                    n_pend = {i_data_byte, 8'd0};
                end else begin
                    n_pend = {r_pend[15:8], i_data_byte};
                end
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'd0;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    assign o_stat.held_cnt = r_cnt;
    assign o_stat.push     = o_push;

endmodule

`default_nettype wire

// File: hw/rtl/b64se_queue.sv
// Two-entry group queue between the front and back ends.
// Depends on b64se_pkg.
`default_nettype none

module b64se_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  b64se_pkg::t_grp     i_grp,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output b64se_pkg::t_grp     o_grp
);
    import b64se_pkg::*;

    t_grp       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == QUEUE_DEPTH);
    assign o_valid = (r_cnt != 2'd0);
    assign o_grp   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // occupancy update
    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_grp;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/b64se_back.sv
// Back end: expands one group into four characters, one word per cycle while the output port is ready.
// Depends on b64se_pkg.
`default_nettype none

module b64se_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  b64se_pkg::t_grp     i_q_grp,
    output logic                o_q_pop,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [6:0]          o_out_char,
    output logic                o_last_char
);
    import b64se_pkg::*;

    t_grp       r_cur;
    logic       r_busy;
    logic       n_busy;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_ov;
    logic       n_ov;
    logic [6:0] r_char;
    logic [6:0] n_char;
    logic       r_last;
    logic       n_last;
    logic       w_adv;
    logic [5:0] w_sext;

    // sextet select for the current character
    always_comb begin
        case (r_idx)
            2'd0:    w_sext = r_cur.b0[7:2];
            2'd1:    w_sext = {r_cur.b0[1:0], r_cur.b1[7:4]};
            2'd2:    w_sext = {r_cur.b1[3:0], r_cur.b2[7:6]};
            default: w_sext = r_cur.b2[5:0];
        endcase
    end

    // output register advance and group pop
    always_comb begin
        w_adv   = r_busy && (!r_ov || i_m_tready);
        o_q_pop = !r_busy || (w_adv && (r_idx == CHAR_IDX_LAST));
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_ov    = r_ov && !i_m_tready;
        n_char  = r_char;
        n_last  = r_last;
        if (w_adv) begin
            n_ov   = 1'b1;
            n_char = b64_char(w_sext);
            n_last = 1'b0;
            if ((r_idx == 2'd2) && (r_cur.kind == GRP_ONE)) begin
                n_char = PAD_CHAR;
            end
            if (r_idx == CHAR_IDX_LAST) begin
                if (r_cur.kind != GRP_FULL) begin
                    n_char = PAD_CHAR;
                    n_last = 1'b1;
                end else begin
                    n_last = r_cur.eom;
                end
                n_busy = 1'b0;
            end
            n_idx = r_idx + 2'd1;
        end
        if (o_q_pop && i_q_valid) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ov   <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        if (o_q_pop && i_q_valid) begin
            r_cur <= i_q_grp;
        end
    end

    assign o_m_tvalid  = r_ov;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

// File: hw/rtl/base64_stream_encoder_core.sv
// Base64 stream encoder: one byte word in, base64 characters out, '=' padded.
// Throughput: the back end emits one character per cycle while the output port is ready;
// three bytes make four characters, so the output port sets the rate of a long message.
// A two-entry group queue lets the front keep taking bytes while output stalls.
// Reset (synchronous, active low) clears held bytes, queue and output valid.
`default_nettype none

`include "base64_stream_encoder_core_macros.svh"

module base64_stream_encoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] out_char, [7] zero
    output logic        o_m_tlast    // last_char
);
    import b64se_pkg::*;

    logic        w_push;
    t_grp        w_push_grp;
    t_front_stat w_fstat;
    logic        w_q_full;
    logic        w_q_valid;
    t_grp        w_q_grp;
    logic        w_q_pop;
    logic [6:0]  w_char;

    b64se_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .o_s_tready       (o_s_tready),
        .i_data_byte      (i_s_tdata),
        .i_end_of_message (i_s_tlast),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_grp            (w_push_grp),
        .o_stat           (w_fstat)
    );

    b64se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_push_grp),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_grp   (w_q_grp)
    );

    b64se_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_grp     (w_q_grp),
        .o_q_pop     (w_q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_out_char  (w_char),
        .o_last_char (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

    // checks
    `B64SE_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, w_fstat.push, !w_q_full, "push into full queue")
    `B64SE_ASSERT_IMPLY(a_held_cnt, i_clk, i_rst_n, 1'b1, w_fstat.held_cnt != 2'd3, "three bytes held")
    `B64SE_ASSERT_IMPLY(a_ascii, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[7] == 1'b0, "non-ASCII output")
    `B64SE_ASSERT_NEXT(a_push_fill, i_clk, i_rst_n, w_fstat.push && !w_q_pop, w_q_valid, "pushed group lost")

endmodule

`default_nettype wire
